// ===== src/ipsl_pkg.sv =====
`default_nettype none
package ipsl_pkg;

   localparam int FRAC_BITS   = 8;
   localparam int GAIN_W      = 16;
   localparam int SPEED_W     = 10;
   localparam int STATUS_W    = 4;
   localparam int IN_W        = 16;
   localparam int TGT_W       = 20;
   localparam int ERR_W       = 21;
   localparam int ACC_W       = 16;
   localparam int DUTY_W      = 8;
   localparam int SMOOTH_W    = SPEED_W + FRAC_BITS;
   localparam int DIFF_W      = 26;
   localparam int DP_W        = ERR_W + 1;
   localparam int DD_W        = ERR_W + 3;
   localparam int SUM_W       = DD_W + GAIN_W + 2;
   localparam int GAIN_SHIFT  = 8;
   localparam int DELTA_W     = SUM_W - GAIN_SHIFT;
   localparam int ROUND_HALF  = 1 << (GAIN_SHIFT - 1);
   localparam int ALPHA_NUM   = 51;
   localparam int ALPHA_SHIFT = 8;
   localparam int ALPHA_PW    = SMOOTH_W + 6;

   localparam int ONE         = 1 << FRAC_BITS;
   localparam int OUT_LIMIT   = 100 * ONE;
   localparam int ZERO_STOP   = (ONE - 1) / 10;
   localparam int TGT_MAX     = (1 << (TGT_W - 1)) - 1;
   localparam int TGT_MIN     = -(1 << (TGT_W - 1));
   localparam int ERR_MAX     = (1 << (ERR_W - 1)) - 1;
   localparam int ERR_MIN     = -(1 << (ERR_W - 1));

   localparam logic [STATUS_W-1:0] STRAIGHT_LO = 4'd3;
   localparam logic [STATUS_W-1:0] STRAIGHT_HI = 4'd5;

   localparam int IN_DATA_W   = 40;
   localparam int OUT_DATA_W  = 48;
   localparam int OUT_USER_W  = 2;
   localparam int OUT_PAD_W   = OUT_DATA_W - TGT_W - ACC_W - DUTY_W;

   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_DATA_W  = 32;

   localparam logic [2:0] REG_GAIN_P    = 3'd0;
   localparam logic [2:0] REG_GAIN_I    = 3'd1;
   localparam logic [2:0] REG_GAIN_D    = 3'd2;
   localparam logic [2:0] REG_STRAIGHT  = 3'd3;
   localparam logic [2:0] REG_CURVE     = 3'd4;
   localparam logic [2:0] REG_SEP_LIMIT = 3'd5;

   localparam logic [SPEED_W-1:0] SEP_LIMIT_RESET = 10'd200;

   typedef struct packed {
      logic [GAIN_W-1:0]  gain_p;
      logic [GAIN_W-1:0]  gain_i;
      logic [GAIN_W-1:0]  gain_d;
      logic [SPEED_W-1:0] straight_speed;
      logic [SPEED_W-1:0] curve_speed;
      logic [SPEED_W-1:0] separation_limit;
   } cfg_type;

   typedef struct packed {
      logic [GAIN_W-1:0]      gain_p;
      logic [GAIN_W-1:0]      gain_i;
      logic [GAIN_W-1:0]      gain_d;
      logic signed [DP_W-1:0]  diff_p;
      logic signed [ERR_W-1:0] err_i;
      logic signed [DD_W-1:0]  diff_d;
   } mac_op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RAMP,
      ST_TARGET,
      ST_ERROR,
      ST_PREP,
      ST_MAC,
      ST_ROUND,
      ST_ACCUM,
      ST_OUT
   } state_type;

endpackage
`default_nettype wire

// ===== src/ipsl_csr.sv =====
`default_nettype none
module ipsl_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [ipsl_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [ipsl_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [ipsl_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                 csr_pready,
   output ipsl_pkg::cfg_type                    cfg
);
   import ipsl_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic [2:0] reg_idx;
   logic       wr_en;

   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_GAIN_P:    cfg_in.gain_p           = csr_pwdata[GAIN_W-1:0];
            REG_GAIN_I:    cfg_in.gain_i           = csr_pwdata[GAIN_W-1:0];
            REG_GAIN_D:    cfg_in.gain_d           = csr_pwdata[GAIN_W-1:0];
            REG_STRAIGHT:  cfg_in.straight_speed   = csr_pwdata[SPEED_W-1:0];
            REG_CURVE:     cfg_in.curve_speed      = csr_pwdata[SPEED_W-1:0];
            REG_SEP_LIMIT: cfg_in.separation_limit = csr_pwdata[SPEED_W-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_GAIN_P:    csr_prdata = CSR_DATA_W'(cfg_ff.gain_p);
         REG_GAIN_I:    csr_prdata = CSR_DATA_W'(cfg_ff.gain_i);
         REG_GAIN_D:    csr_prdata = CSR_DATA_W'(cfg_ff.gain_d);
         REG_STRAIGHT:  csr_prdata = CSR_DATA_W'(cfg_ff.straight_speed);
         REG_CURVE:     csr_prdata = CSR_DATA_W'(cfg_ff.curve_speed);
         REG_SEP_LIMIT: csr_prdata = CSR_DATA_W'(cfg_ff.separation_limit);
         default:       csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff                  <= '0;
         cfg_ff.separation_limit <= SEP_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

// ===== src/ipsl_mac.sv =====
`default_nettype none
module ipsl_mac (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire ipsl_pkg::mac_op_type              op,
   output logic                                   done,
   output logic signed [ipsl_pkg::SUM_W-1:0]      sum
);
   import ipsl_pkg::*;

   localparam int CNT_W = $clog2(GAIN_W);

   logic [GAIN_W-1:0]       gp_ff, gp_in;
   logic [GAIN_W-1:0]       gi_ff, gi_in;
   logic [GAIN_W-1:0]       gd_ff, gd_in;
   logic signed [DP_W-1:0]  dp_ff, dp_in;
   logic signed [ERR_W-1:0] ei_ff, ei_in;
   logic signed [DD_W-1:0]  dd_ff, dd_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;

   logic signed [SUM_W-1:0] ext_p, ext_i, ext_d;
   logic signed [SUM_W-1:0] pp_p, pp_i, pp_d;

   assign ext_p = SUM_W'(dp_ff);
   assign ext_i = SUM_W'(ei_ff);
   assign ext_d = SUM_W'(dd_ff);

   // one bit of each gain per cycle, msb first
   assign pp_p = gp_ff[GAIN_W-1] ? ext_p : '0;
   assign pp_i = gi_ff[GAIN_W-1] ? ext_i : '0;
   assign pp_d = gd_ff[GAIN_W-1] ? ext_d : '0;

   assign done = done_ff;
   assign sum  = sum_ff;

   always_comb begin
      gp_in   = gp_ff;
      gi_in   = gi_ff;
      gd_in   = gd_ff;
      dp_in   = dp_ff;
      ei_in   = ei_ff;
      dd_in   = dd_ff;
      sum_in  = sum_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         gp_in   = op.gain_p;
         gi_in   = op.gain_i;
         gd_in   = op.gain_d;
         dp_in   = op.diff_p;
         ei_in   = op.err_i;
         dd_in   = op.diff_d;
         sum_in  = '0;
         cnt_in  = CNT_W'(GAIN_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         sum_in = (sum_ff <<< 1) + pp_p + pp_i + pp_d;
         gp_in  = {gp_ff[GAIN_W-2:0], 1'b0};
         gi_in  = {gi_ff[GAIN_W-2:0], 1'b0};
         gd_in  = {gd_ff[GAIN_W-2:0], 1'b0};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      gp_ff  <= gp_in;
      gi_ff  <= gi_in;
      gd_ff  <= gd_in;
      dp_ff  <= dp_in;
      ei_ff  <= ei_in;
      dd_ff  <= dd_in;
      sum_ff <= sum_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

endmodule
`default_nettype wire

// ===== src/incremental_pid_speed_loop.sv =====
`default_nettype none
// Incremental PID speed loop for up to NUM_MOTORS wheels. Each item is one control tick for one
// motor: the block ramps that motor's target toward the straight or curve speed, applies the
// steering offset, and runs an incremental PID with a one-unit deadband and integral separation,
// giving one result item per tick. One item is in work at a time. A tick outside the deadband
// steps through the ramp, target, error, prep, MAC, round, accumulate and output states; MAC
// waits on the bit-serial multiply-accumulate unit that consumes one bit of each 16-bit gain per
// cycle. A tick inside the deadband skips that unit and goes from prep to output. A finished
// result waits in the output register while the next item is taken in. The user must write gains
// and speeds through the register port only while no item is in work; this is not enforced.
module incremental_pid_speed_loop #(
   parameter int NUM_MOTORS = 2
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // track_status [3:0], steer_offset [19:4], measured_speed [35:20], zero [39:36]
   input  wire logic [ipsl_pkg::IN_DATA_W-1:0]      req_tdata,
   // motor_select [0]
   input  wire logic [0:0]                          req_tuser,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // target_speed [19:0], drive_level [35:20], pwm_duty [43:36], zero [47:44]
   output logic      [ipsl_pkg::OUT_DATA_W-1:0]     rsp_tdata,
   // motor_id [0], updated [1]
   output logic      [ipsl_pkg::OUT_USER_W-1:0]     rsp_tuser,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [ipsl_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire logic [ipsl_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic      [ipsl_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                     csr_pready
);
   import ipsl_pkg::*;

   localparam int MOTOR_W = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;

   cfg_type    cfg;
   mac_op_type mac_op;
   logic       mac_start;
   logic       mac_done;
   logic signed [SUM_W-1:0] mac_sum;

   state_type state_ff, state_in;

   // item registers
   logic [MOTOR_W-1:0]       motor_ff, motor_in;
   logic [STATUS_W-1:0]      status_ff, status_in;
   logic signed [IN_W-1:0]   offset_ff, offset_in;
   logic signed [IN_W-1:0]   meas_ff, meas_in;

   // per-motor state
   logic [SMOOTH_W-1:0]      smooth_ff [NUM_MOTORS];
   logic [SMOOTH_W-1:0]      smooth_in [NUM_MOTORS];
   logic signed [ERR_W-1:0]  err_now_ff [NUM_MOTORS];
   logic signed [ERR_W-1:0]  err_now_in [NUM_MOTORS];
   logic signed [ERR_W-1:0]  err_prev_ff [NUM_MOTORS];
   logic signed [ERR_W-1:0]  err_prev_in [NUM_MOTORS];
   logic signed [ERR_W-1:0]  err_prev2_ff [NUM_MOTORS];
   logic signed [ERR_W-1:0]  err_prev2_in [NUM_MOTORS];
   logic signed [ACC_W-1:0]  accum_ff [NUM_MOTORS];
   logic signed [ACC_W-1:0]  accum_in [NUM_MOTORS];
   logic                     primed_ff, primed_in;

   // working registers
   logic signed [TGT_W-1:0]   target_ff, target_in;
   logic signed [ERR_W-1:0]   e0_ff, e0_in;
   logic signed [ERR_W-1:0]   e1_ff, e1_in;
   logic signed [ERR_W-1:0]   e2_ff, e2_in;
   logic signed [DELTA_W-1:0] delta_ff, delta_in;
   logic                      updated_ff, updated_in;

   // output register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [OUT_DATA_W-1:0]     rsp_data_ff, rsp_data_in;
   logic [OUT_USER_W-1:0]     rsp_user_ff, rsp_user_in;

   // combinational datapath
   logic [MOTOR_W-1:0]        motor_sel;
   logic [SPEED_W-1:0]        speed_sel;
   logic [SMOOTH_W-1:0]       desired;
   logic [SMOOTH_W-1:0]       st_cur;
   logic [SMOOTH_W-1:0]       gap;
   logic [ALPHA_PW-1:0]       ramp_prod;
   logic [SMOOTH_W-1:0]       ramp_step;
   logic [SMOOTH_W-1:0]       ramp_new;
   logic signed [TGT_W:0]     smooth_ext, offset_ext, tsum;
   logic signed [TGT_W-1:0]   target_sat;
   logic signed [DIFF_W-1:0]  tgt_ext, meas_ext, err_diff;
   logic signed [ERR_W-1:0]   err_sat;
   logic                      outside_band;
   logic signed [ERR_W:0]     sep_lim;
   logic                      in_sep;
   logic signed [DD_W-1:0]    e0_x, e1_x, e2_x;
   logic signed [DP_W-1:0]    diff_p;
   logic signed [DD_W-1:0]    diff_d;
   logic signed [ERR_W-1:0]   err_i;
   logic signed [SUM_W-1:0]   rsum, rshift;
   logic signed [DELTA_W:0]   acc_old_x, acc_sum;
   logic signed [ACC_W-1:0]   acc_new;
   logic                      zero_stop;
   logic signed [ACC_W-1:0]   acc_cur, acc_q;
   logic                      duty_adj;
   logic signed [DUTY_W-1:0]  duty;

   ipsl_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   ipsl_mac u_mac (
      .clock (clock),
      .reset (reset),
      .start (mac_start),
      .op    (mac_op),
      .done  (mac_done),
      .sum   (mac_sum)
   );

   // motor numbers past the last one map to the last motor
   assign motor_sel = (int'(req_tuser[0]) >= NUM_MOTORS) ? MOTOR_W'(NUM_MOTORS - 1)
                                                           : MOTOR_W'(req_tuser[0]);

   assign speed_sel = (status_ff inside {[STRAIGHT_LO:STRAIGHT_HI]}) ? cfg.straight_speed
                                                                     : cfg.curve_speed;
   assign desired   = {speed_sel, {FRAC_BITS{1'b0}}};

   // ramp up by 51/256 of the gap, drop at once
   assign st_cur    = primed_ff ? smooth_ff[motor_ff] : desired;
   assign gap       = desired - st_cur;
   assign ramp_prod = ALPHA_PW'(gap) * ALPHA_PW'(ALPHA_NUM);
   assign ramp_step = SMOOTH_W'(ramp_prod >> ALPHA_SHIFT);
   assign ramp_new  = (desired > st_cur) ? st_cur + ramp_step : desired;

   assign smooth_ext = signed'({1'b0, {(TGT_W - SMOOTH_W){1'b0}}, smooth_ff[motor_ff]});
   assign offset_ext = (TGT_W + 1)'(offset_ff);
   assign tsum       = (motor_ff == '0) ? smooth_ext + offset_ext : smooth_ext - offset_ext;
   assign target_sat = (tsum > TGT_MAX) ? TGT_W'(TGT_MAX) :
                       (tsum < TGT_MIN) ? TGT_W'(TGT_MIN) : tsum[TGT_W-1:0];

   assign tgt_ext  = DIFF_W'(target_ff);
   assign meas_ext = DIFF_W'(meas_ff);
   assign err_diff = tgt_ext - (meas_ext <<< FRAC_BITS);
   assign err_sat  = (err_diff > ERR_MAX) ? ERR_W'(ERR_MAX) :
                     (err_diff < ERR_MIN) ? ERR_W'(ERR_MIN) : err_diff[ERR_W-1:0];

   assign outside_band = (e0_ff > ONE) || (e0_ff < -ONE);
   assign sep_lim      = signed'({{(ERR_W + 1 - SPEED_W - FRAC_BITS){1'b0}},
                                  cfg.separation_limit, {FRAC_BITS{1'b0}}});
   assign in_sep       = (e0_ff <= sep_lim) && (e0_ff >= -sep_lim);
   assign e0_x         = DD_W'(e0_ff);
   assign e1_x         = DD_W'(e1_ff);
   assign e2_x         = DD_W'(e2_ff);
   assign diff_p       = DP_W'(e0_x - e1_x);
   assign diff_d       = e0_x - (e1_x <<< 1) + e2_x;
   assign err_i        = in_sep ? e0_ff : '0;

   assign mac_op.gain_p = cfg.gain_p;
   assign mac_op.gain_i = cfg.gain_i;
   assign mac_op.gain_d = cfg.gain_d;
   assign mac_op.diff_p = diff_p;
   assign mac_op.err_i  = err_i;
   assign mac_op.diff_d = diff_d;

   // round to nearest, ties up
   assign rsum   = mac_sum + SUM_W'(ROUND_HALF);
   assign rshift = rsum >>> GAIN_SHIFT;

   assign acc_old_x = (DELTA_W + 1)'(accum_ff[motor_ff]);
   assign acc_sum   = acc_old_x + (DELTA_W + 1)'(delta_ff);
   assign zero_stop = (target_ff <= ZERO_STOP) && (target_ff >= -ZERO_STOP) && (meas_ff == '0);
   assign acc_new   = zero_stop ? '0 :
                      (acc_sum > OUT_LIMIT)  ? ACC_W'(OUT_LIMIT) :
                      (acc_sum < -OUT_LIMIT) ? ACC_W'(-OUT_LIMIT) : acc_sum[ACC_W-1:0];

   // duty truncates toward zero
   assign acc_cur  = accum_ff[motor_ff];
   assign acc_q    = acc_cur >>> FRAC_BITS;
   assign duty_adj = acc_cur[ACC_W-1] && (acc_cur[FRAC_BITS-1:0] != '0);
   assign duty     = acc_q[DUTY_W-1:0] + {{(DUTY_W - 1){1'b0}}, duty_adj};

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   always_comb begin
      state_in     = state_ff;
      req_tready   = 1'b0;
      mac_start    = 1'b0;
      motor_in     = motor_ff;
      status_in    = status_ff;
      offset_in    = offset_ff;
      meas_in      = meas_ff;
      smooth_in    = smooth_ff;
      err_now_in   = err_now_ff;
      err_prev_in  = err_prev_ff;
      err_prev2_in = err_prev2_ff;
      accum_in     = accum_ff;
      primed_in    = primed_ff;
      target_in    = target_ff;
      e0_in        = e0_ff;
      e1_in        = e1_ff;
      e2_in        = e2_ff;
      delta_in     = delta_ff;
      updated_in   = updated_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               motor_in  = motor_sel;
               status_in = req_tdata[STATUS_W-1:0];
               offset_in = req_tdata[STATUS_W +: IN_W];
               meas_in   = req_tdata[STATUS_W + IN_W +: IN_W];
               state_in  = ST_RAMP;
            end
         end
         ST_RAMP: begin
            if (!primed_ff) begin
               for (int k = 0; k < NUM_MOTORS; k++) begin
                  smooth_in[k] = desired;
               end
            end
            smooth_in[motor_ff] = ramp_new;
            primed_in           = 1'b1;
            state_in            = ST_TARGET;
         end
         ST_TARGET: begin
            target_in = target_sat;
            state_in  = ST_ERROR;
         end
         ST_ERROR: begin
            e0_in                  = err_sat;
            e1_in                  = err_now_ff[motor_ff];
            e2_in                  = err_prev_ff[motor_ff];
            err_now_in[motor_ff]   = err_sat;
            err_prev_in[motor_ff]  = err_now_ff[motor_ff];
            err_prev2_in[motor_ff] = err_prev_ff[motor_ff];
            state_in               = ST_PREP;
         end
         ST_PREP: begin
            updated_in = outside_band;
            if (outside_band) begin
               mac_start = 1'b1;
               state_in  = ST_MAC;
            end else begin
               state_in  = ST_OUT;
            end
         end
         ST_MAC: begin
            if (mac_done) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            delta_in = rshift[DELTA_W-1:0];
            state_in = ST_ACCUM;
         end
         ST_ACCUM: begin
            accum_in[motor_ff] = acc_new;
            state_in           = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {{OUT_PAD_W{1'b0}}, duty, acc_cur, target_ff};
               rsp_user_in  = {updated_ff, motor_ff[0]};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      motor_ff    <= motor_in;
      status_ff   <= status_in;
      offset_ff   <= offset_in;
      meas_ff     <= meas_in;
      target_ff   <= target_in;
      e0_ff       <= e0_in;
      e1_ff       <= e1_in;
      e2_ff       <= e2_in;
      delta_ff    <= delta_in;
      updated_ff  <= updated_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      if (reset) begin
         for (int k = 0; k < NUM_MOTORS; k++) begin
            smooth_ff[k]    <= '0;
            err_now_ff[k]   <= '0;
            err_prev_ff[k]  <= '0;
            err_prev2_ff[k] <= '0;
            accum_ff[k]     <= '0;
         end
         primed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         smooth_ff    <= smooth_in;
         err_now_ff   <= err_now_in;
         err_prev_ff  <= err_prev_in;
         err_prev2_ff <= err_prev2_in;
         accum_ff     <= accum_in;
         primed_ff    <= primed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

// ===== src/ipsl_checker.sv =====
`default_nettype none
module ipsl_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               req_tvalid,
   input wire logic                               req_tready,
   input wire logic                               rsp_tvalid,
   input wire logic                               rsp_tready,
   input wire logic [ipsl_pkg::OUT_DATA_W-1:0]    rsp_tdata,
   input wire logic [ipsl_pkg::OUT_USER_W-1:0]    rsp_tuser
);
   import ipsl_pkg::*;

   logic signed [ACC_W-1:0]  drive;
   logic signed [DUTY_W-1:0] duty;
   logic signed [ACC_W-1:0]  drive_q;
   logic signed [DUTY_W-1:0] duty_exp;

   assign drive    = rsp_tdata[TGT_W +: ACC_W];
   assign duty     = rsp_tdata[TGT_W + ACC_W +: DUTY_W];
   assign drive_q  = drive >>> FRAC_BITS;
   assign duty_exp = drive_q[DUTY_W-1:0] +
                     {{(DUTY_W - 1){1'b0}},
                      (drive[ACC_W-1] && (drive[FRAC_BITS-1:0] != '0))};

   // drive level stays inside the output clamp
   a_drive_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (drive <= OUT_LIMIT) && (drive >= -OUT_LIMIT))
      else $error("drive level outside clamp");

   // duty is the drive level truncated toward zero
   a_duty_match: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (duty == duty_exp))
      else $error("pwm duty does not match drive level");

   // one item in work at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second item taken while one is in work");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

endmodule

bind incremental_pid_speed_loop ipsl_checker u_ipsl_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire
